// ===== design/fta_pkg.sv =====
// fta_pkg: constants, status codes and command codes for the file table block allocator
// no dependencies
package fta_pkg;
    localparam int NUM_BLOCKS      = 128;
    localparam int NUM_ENTRIES     = 16;
    localparam int BLOCKS_PER_FILE = 8;
    localparam int BLK_W  = $clog2(NUM_BLOCKS);
    localparam int ENT_W  = $clog2(NUM_ENTRIES);
    localparam int BPF_W  = $clog2(BLOCKS_PER_FILE);
    localparam int PTR_W  = ENT_W + BPF_W;
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);

    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_MAP    = 2'd2;
    localparam logic [1:0] CMD_LIST   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_SPACE  = 3'd1;
    localparam logic [2:0] ST_NO_ENTRY  = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX = 3'd4;
    localparam logic [2:0] ST_TOO_LARGE = 3'd5;
    localparam logic [2:0] ST_NO_FILES  = 3'd6;
endpackage

// ===== design/fta_ram.sv =====
// fta_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module fta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/file_table_block_allocator.sv =====
// file_table_block_allocator: top level, free map, file table and command sequencer
// depends on fta_pkg and fta_ram
//
// usage: one request at a time on the input channel (cmd, file_name, req_size,
// block_index); results on the output channel, o_last marks the final result of a
// request. list gives one result per used entry or one if none; others exactly one.
// the free map (one bit per block) sits in an fta_ram, the free count in flip-flops;
// entry names, sizes and block pointers sit in fta_ram memories (registered read).
// steps from request accepted to result:
//   create : one map bit per cycle, stops once req_size blocks are taken; a
//            rejected request goes straight to its result
//   delete : one entry per cycle, then reads each block pointer and frees its block
//   map    : scans the entries, then reads the pointer at block_index if in range
//   list   : scans the entries and gives one result per used entry
// requests are taken only in idle, so o_stall is high from acceptance until the
// final result has moved into the output register.
// reset (synchronous, active low) clears the used flags, then a clearing pass of
// the whole free map frees every block except block zero, with o_stall high.
// a result waits in the output register while i_stall is high; the next result
// waits in the sequencer, which holds in its output state.
module file_table_block_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_cmd,
    input  logic [63:0]                   i_file_name,
    input  logic [3:0]                    i_req_size,
    input  logic [2:0]                    i_block_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_status,
    output logic [3:0]                    o_entry_index,
    output logic [6:0]                    o_block_number,
    output logic [63:0]                   o_listed_name,
    output logic [3:0]                    o_listed_size,
    output logic                          o_last
);
    import fta_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SRCH  = 9'b000000010,  // entry scan, read issued previous cycle
        S_ALLOC = 9'b000000100,  // free map scan for create, read issued previous cycle
        S_FREE  = 9'b000001000,  // read pointer for delete
        S_FREEW = 9'b000010000,  // pointer data back, release block
        S_MAPW  = 9'b000100000,  // pointer data back for map
        S_OUT   = 9'b001000000,  // result ready, waiting for the output register
        S_LIST  = 9'b010000000,  // list data back
        S_CLR   = 9'b100000000   // free map clearing pass after reset
    } t_state;

    t_state                 r_state;
    logic [CNT_W-1:0]       r_nfree;
    logic [NUM_ENTRIES-1:0] r_used;
    logic [1:0]             r_cmd;
    logic [63:0]            r_name;
    logic [3:0]             r_size;
    logic [BPF_W-1:0]       r_bidx;
    logic [ENT_W:0]         r_ent;     // scan position, one bit wider to hold the end
    logic [ENT_W-1:0]       r_hit;
    logic [BLK_W:0]         r_blk;     // map scan position, one ahead of the data
    logic [3:0]             r_got;
    logic                   r_list_more; // list continues after the held result

    // result being assembled
    logic [2:0]             r_ost;
    logic [3:0]             r_oent;
    logic [6:0]             r_oblk;
    logic [63:0]            r_oname;
    logic [3:0]             r_osize;
    logic                   r_olast;

    // output register
    logic                   r_ovalid;
    logic [2:0]             r_res_st;
    logic [3:0]             r_res_ent;
    logic [6:0]             r_res_blk;
    logic [63:0]            r_res_name;
    logic [3:0]             r_res_size;
    logic                   r_res_last;

    // memories
    logic                   name_we, size_we, ptr_we, map_we;
    logic [ENT_W-1:0]       name_wa, name_ra;
    logic [63:0]            name_rd;
    logic [3:0]             size_rd;
    logic [PTR_W-1:0]       ptr_wa, ptr_ra;
    logic [BLK_W-1:0]       ptr_wd, ptr_rd;
    logic [BLK_W-1:0]       map_wa, map_ra;
    logic                   map_wd, map_rd;

    fta_ram #(.WIDTH(64), .DEPTH(NUM_ENTRIES)) u_name (
        .i_clk(i_clk), .i_we(name_we), .i_waddr(name_wa), .i_wdata(r_name),
        .i_raddr(name_ra), .o_rdata(name_rd));
    fta_ram #(.WIDTH(4), .DEPTH(NUM_ENTRIES)) u_size (
        .i_clk(i_clk), .i_we(size_we), .i_waddr(name_wa), .i_wdata(r_size),
        .i_raddr(name_ra), .o_rdata(size_rd));
    fta_ram #(.WIDTH(BLK_W), .DEPTH(NUM_ENTRIES*BLOCKS_PER_FILE)) u_ptr (
        .i_clk(i_clk), .i_we(ptr_we), .i_waddr(ptr_wa), .i_wdata(ptr_wd),
        .i_raddr(ptr_ra), .o_rdata(ptr_rd));
    // free map, 1 = free
    fta_ram #(.WIDTH(1), .DEPTH(NUM_BLOCKS)) u_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_wa), .i_wdata(map_wd),
        .i_raddr(map_ra), .o_rdata(map_rd));

    // lowest unused entry, priority over a narrow vector
    logic             free_ent_ok;
    logic [ENT_W-1:0] free_ent;
    always_comb begin
        free_ent_ok = 1'b0;
        free_ent    = '0;
        for (int k = NUM_ENTRIES - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                free_ent_ok = 1'b1;
                free_ent    = ENT_W'(k);
            end
        end
    end

    logic [ENT_W-1:0] ent_lo;
    logic [ENT_W-1:0] prev_ent;
    logic [BLK_W-1:0] blk_lo;
    logic [BLK_W-1:0] prev_blk;
    logic             in_acc, out_acc, out_free;
    assign ent_lo   = r_ent[ENT_W-1:0];
    assign prev_ent = ENT_W'(r_ent - 1'b1);
    assign blk_lo   = r_blk[BLK_W-1:0];
    assign prev_blk = BLK_W'(r_blk - 1'b1);
    assign in_acc   = i_valid && (r_state == S_IDLE);
    assign out_acc  = r_ovalid && !i_stall;
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    // memory addressing
    always_comb begin
        name_we = 1'b0;
        size_we = 1'b0;
        name_wa = free_ent;
        name_ra = ent_lo;
        ptr_we  = 1'b0;
        ptr_wa  = {free_ent, r_got[BPF_W-1:0]};
        ptr_wd  = prev_blk;
        ptr_ra  = {r_hit, r_got[BPF_W-1:0]};
        map_we  = 1'b0;
        map_wa  = prev_blk;
        map_wd  = 1'b0;
        map_ra  = blk_lo;
        case (r_state)
            S_IDLE: begin
                // first entry and first block read ahead of a scan
                name_ra = '0;
                map_ra  = '0;
            end
            S_CLR: begin
                map_we = 1'b1;
                map_wa = blk_lo;
                map_wd = (r_blk != '0);
            end
            S_ALLOC: begin
                if (r_blk == (BLK_W+1)'(1)) begin
                    // entry header written once at the start of allocation
                    name_we = 1'b1;
                    size_we = 1'b1;
                end
                if (r_got != r_size && map_rd) begin
                    // take block prev_blk
                    ptr_we = 1'b1;
                    map_we = 1'b1;
                end
            end
            S_SRCH: begin
                if (r_cmd == CMD_MAP) begin
                    ptr_ra = {prev_ent, r_bidx};
                end
            end
            S_FREEW: begin
                map_we = 1'b1;
                map_wa = ptr_rd;
                map_wd = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_blk    <= '0;
            r_nfree  <= CNT_W'(NUM_BLOCKS - 1);
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (out_acc) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd  <= i_cmd;
                        r_name <= i_file_name;
                        r_size <= i_req_size;
                        r_bidx <= i_block_index;
                        r_ent  <= '0;
                        r_blk  <= '0;
                        r_got  <= '0;
                        r_oent <= '0; r_oblk <= '0; r_oname <= '0; r_osize <= '0;
                        r_olast <= 1'b1;
                        r_list_more <= 1'b0;
                        case (i_cmd)
                            CMD_CREATE: begin
                                if (i_req_size > 4'(BLOCKS_PER_FILE)) begin
                                    r_ost <= ST_TOO_LARGE; r_state <= S_OUT;
                                end else if (r_nfree < CNT_W'(i_req_size)) begin
                                    r_ost <= ST_NO_SPACE; r_state <= S_OUT;
                                end else if (!free_ent_ok) begin
                                    r_ost <= ST_NO_ENTRY; r_state <= S_OUT;
                                end else begin
                                    r_blk   <= (BLK_W+1)'(1);
                                    r_state <= S_ALLOC;
                                end
                            end
                            CMD_LIST: begin
                                if (r_used == '0) begin
                                    r_ost <= ST_NO_FILES; r_state <= S_OUT;
                                end else begin
                                    r_ent <= (ENT_W+1)'(1);
                                    r_state <= S_LIST;
                                end
                            end
                            default: begin
                                r_ent   <= (ENT_W+1)'(1);
                                r_state <= S_SRCH;
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    r_blk <= r_blk + 1'b1;
                    if (blk_lo == BLK_W'(NUM_BLOCKS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_SRCH: begin
                    // data of entry prev_ent is on the ram outputs
                    if (r_used[prev_ent] && name_rd == r_name) begin
                        r_hit   <= prev_ent;
                        r_oent  <= 4'(prev_ent);
                        r_osize <= size_rd;
                        r_size  <= size_rd;
                        if (r_cmd == CMD_DELETE) begin
                            r_used[prev_ent] <= 1'b0;
                            r_ost   <= ST_OK;
                            r_state <= (size_rd == '0) ? S_OUT : S_FREE;
                        end else if (4'(r_bidx) >= size_rd) begin
                            r_ost   <= ST_BAD_INDEX;
                            r_state <= S_OUT;
                        end else begin
                            r_ost   <= ST_OK;
                            r_state <= S_MAPW;
                        end
                    end else if (r_ent == (ENT_W+1)'(NUM_ENTRIES)) begin
                        r_ost   <= ST_NOT_FOUND;
                        r_state <= S_OUT;
                    end else begin
                        r_ent <= r_ent + 1'b1;
                    end
                end
                S_MAPW: begin
                    r_oblk  <= 7'(ptr_rd);
                    r_state <= S_OUT;
                end
                S_FREE: begin
                    r_state <= S_FREEW;
                end
                S_FREEW: begin
                    r_nfree <= r_nfree + 1'b1;
                    r_got   <= r_got + 1'b1;
                    r_state <= (r_got + 1'b1 == r_size) ? S_OUT : S_FREE;
                end
                S_ALLOC: begin
                    // map bit of block prev_blk is on the ram output
                    if (r_got == r_size) begin
                        r_used[free_ent] <= 1'b1;
                        r_ost   <= ST_OK;
                        r_oent  <= 4'(free_ent);
                        r_osize <= r_size;
                        r_state <= S_OUT;
                    end else begin
                        if (map_rd) begin
                            r_nfree <= r_nfree - 1'b1;
                            r_got   <= r_got + 1'b1;
                        end
                        r_blk <= r_blk + 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_res_st   <= r_ost;
                        r_res_ent  <= r_oent;
                        r_res_blk  <= r_oblk;
                        r_res_name <= r_oname;
                        r_res_size <= r_osize;
                        r_res_last <= r_olast;
                        if (r_list_more) begin
                            r_list_more <= 1'b0;
                            r_ent   <= r_ent + 1'b1;
                            r_state <= S_LIST;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_LIST: begin
                    // data of entry prev_ent is on the ram outputs
                    if (r_used[prev_ent]) begin
                        r_ost   <= ST_OK;
                        r_oent  <= 4'(prev_ent);
                        r_oname <= name_rd;
                        r_osize <= size_rd;
                        r_olast <= ((r_used >> r_ent) == '0);
                        r_list_more <= ((r_used >> r_ent) != '0);
                        r_state <= S_OUT;
                    end else begin
                        r_ent <= r_ent + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_res_st;
    assign o_entry_index  = r_res_ent;
    assign o_block_number = r_res_blk;
    assign o_listed_name  = r_res_name;
    assign o_listed_size  = r_res_size;
    assign o_last         = r_res_last;
endmodule

// ===== dv/tb_file_table_block_allocator.sv =====
`timescale 1ns / 1ps
// tb_file_table_block_allocator: self-checking bench for the file table block allocator
// depends on fta_pkg and file_table_block_allocator; carries its own model of table and map
module tb_file_table_block_allocator;
    import fta_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 400;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  entry;
        logic [6:0]  block;
        logic [63:0] name;
        logic [3:0]  size;
        logic        last;
    } t_fs_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_cmd;
    logic [63:0] i_file_name;
    logic [3:0]  i_req_size;
    logic [2:0]  i_block_index;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_status;
    logic [3:0]  o_entry_index;
    logic [6:0]  o_block_number;
    logic [63:0] o_listed_name;
    logic [3:0]  o_listed_size;
    logic        o_last;

    file_table_block_allocator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_file_name    (i_file_name),
        .i_req_size     (i_req_size),
        .i_block_index  (i_block_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_entry_index  (o_entry_index),
        .o_block_number (o_block_number),
        .o_listed_name  (o_listed_name),
        .o_listed_size  (o_listed_size),
        .o_last         (o_last)
    );

    // shadow copy of the allocator state
    logic [NUM_BLOCKS-1:0] shadow_free;
    logic [NUM_ENTRIES-1:0] shadow_used;
    logic [63:0] shadow_name [NUM_ENTRIES];
    logic [3:0]  shadow_size [NUM_ENTRIES];
    logic [6:0]  shadow_blocks [NUM_ENTRIES][BLOCKS_PER_FILE];

    t_fs_result pending_results[$];
    int         mismatches;
    int         burst_left;
    int         idle_cycles;
    logic [63:0] name_pool [6];

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // model: expected results for one accepted request
    // ------------------------------------------------------------------
    function automatic int lookup_entry(logic [63:0] nm);
        for (int e = 0; e < NUM_ENTRIES; e++)
            if (shadow_used[e] && shadow_name[e] == nm)
                return e;
        return -1;
    endfunction

    task automatic push_result(logic [2:0] st, int ent, logic [6:0] blk,
                               logic [63:0] nm, logic [3:0] sz, logic lst);
        t_fs_result r;
        r.status = st;
        r.entry  = ent[3:0];
        r.block  = blk;
        r.name   = nm;
        r.size   = sz;
        r.last   = lst;
        pending_results.push_back(r);
    endtask

    task automatic predict_request(logic [1:0] cmd, logic [63:0] nm, logic [3:0] rsz,
                                   logic [2:0] bidx);
        int e;
        int got;
        int last_used;
        case (cmd)
            CMD_CREATE: begin
                e = -1;
                for (int k = NUM_ENTRIES - 1; k >= 0; k--)
                    if (!shadow_used[k]) e = k;
                if (rsz > BLOCKS_PER_FILE) begin
                    push_result(ST_TOO_LARGE, 0, 0, 0, 0, 1'b1);
                end else if ($countones(shadow_free) < rsz) begin
                    push_result(ST_NO_SPACE, 0, 0, 0, 0, 1'b1);
                end else if (e < 0) begin
                    push_result(ST_NO_ENTRY, 0, 0, 0, 0, 1'b1);
                end else begin
                    shadow_used[e] = 1'b1;
                    shadow_name[e] = nm;
                    shadow_size[e] = rsz;
                    got = 0;
                    // lowest-numbered free blocks, ascending
                    for (int b = 0; b < NUM_BLOCKS && got < rsz; b++) begin
                        if (shadow_free[b]) begin
                            shadow_free[b] = 1'b0;
                            shadow_blocks[e][got] = b[6:0];
                            got++;
                        end
                    end
                    push_result(ST_OK, e, 0, 0, rsz, 1'b1);
                end
            end
            CMD_DELETE: begin
                e = lookup_entry(nm);
                if (e < 0) begin
                    push_result(ST_NOT_FOUND, 0, 0, 0, 0, 1'b1);
                end else begin
                    for (int i = 0; i < shadow_size[e]; i++)
                        shadow_free[shadow_blocks[e][i]] = 1'b1;
                    shadow_used[e] = 1'b0;
                    push_result(ST_OK, e, 0, 0, shadow_size[e], 1'b1);
                end
            end
            CMD_MAP: begin
                e = lookup_entry(nm);
                if (e < 0)
                    push_result(ST_NOT_FOUND, 0, 0, 0, 0, 1'b1);
                else if (bidx >= shadow_size[e])
                    push_result(ST_BAD_INDEX, e, 0, 0, shadow_size[e], 1'b1);
                else
                    push_result(ST_OK, e, shadow_blocks[e][bidx], 0, shadow_size[e], 1'b1);
            end
            default: begin
                last_used = -1;
                for (int k = 0; k < NUM_ENTRIES; k++)
                    if (shadow_used[k]) last_used = k;
                if (last_used < 0) begin
                    push_result(ST_NO_FILES, 0, 0, 0, 0, 1'b1);
                end else begin
                    for (int k = 0; k < NUM_ENTRIES; k++)
                        if (shadow_used[k])
                            push_result(ST_OK, k, 0, shadow_name[k], shadow_size[k],
                                        k == last_used);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // request driver: bursts of back-to-back requests, random gaps between
    // ------------------------------------------------------------------
    task automatic send_request(logic [1:0] cmd, logic [63:0] nm, logic [3:0] rsz,
                                logic [2:0] bidx);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_file_name   <= nm;
        i_req_size    <= rsz;
        i_block_index <= bidx;
        // accepted at the first edge where the block is not stalling us
        do @(posedge i_clk); while (o_stall);
        predict_request(cmd, nm, rsz, bidx);
        burst_left--;
    endtask

    // hold off new requests until every expected result has come back
    task automatic drain_results();
        i_valid    <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s: got %0h expected %0h at %0t", field, got, want, $time);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_fs_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 64'd1, 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                if (o_entry_index !== want.entry)
                    report_mismatch("entry_index", 64'(o_entry_index), 64'(want.entry));
                if (o_block_number !== want.block)
                    report_mismatch("block_number", 64'(o_block_number), 64'(want.block));
                if (o_listed_name !== want.name)
                    report_mismatch("listed_name", o_listed_name, want.name);
                if (o_listed_size !== want.size)
                    report_mismatch("listed_size", 64'(o_listed_size), 64'(want.size));
                if (o_last !== want.last)
                    report_mismatch("last", 64'(o_last), 64'(want.last));
            end
        end
    end

    // result-side stall: switches between free flow, light and heavy stalling
    int stall_mode;
    int stall_run;
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_run  = $urandom_range(5, 60);
        end
        stall_run--;
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // watchdog: cycles in which neither side moves anything
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_request(CMD_LIST, 64'd0, 4'd0, 3'd0);                 // empty table
        send_request(CMD_CREATE, 64'h41, 4'd15, 3'd0);             // oversized
        send_request(CMD_CREATE, 64'h41, 4'd9, 3'd0);              // just over the limit
        send_request(CMD_CREATE, '1, 4'd8, 3'd7);                  // full-size file
        send_request(CMD_MAP, '1, 4'd0, 3'd7);                     // last block of it
        send_request(CMD_MAP, '1, 4'd0, 3'd0);
        send_request(CMD_CREATE, 64'd0, 4'd0, 3'd0);               // zero-size file
        send_request(CMD_MAP, 64'd0, 4'd0, 3'd0);                  // index past end
        send_request(CMD_CREATE, 64'h6f6c6c6568, 4'd3, 3'd0);
        send_request(CMD_CREATE, 64'h6f6c6c6568, 4'd2, 3'd0);      // duplicate name
        send_request(CMD_MAP, 64'h6f6c6c6568, 4'd15, 3'd2);        // lowest match, its last block
        send_request(CMD_MAP, 64'h6f6c6c6568, 4'd0, 3'd1);
        send_request(CMD_DELETE, 64'h6f6c6c6568, 4'd0, 3'd0);      // frees lowest match
        send_request(CMD_MAP, 64'h6f6c6c6568, 4'd0, 3'd1);         // now the second one
        send_request(CMD_DELETE, 64'h1234, 4'd0, 3'd0);            // unknown name
        send_request(CMD_MAP, 64'h1234, 4'd0, 3'd0);
        send_request(CMD_CREATE, 64'h8000_0000_0000_0001, 4'd1, 3'd0); // reuses freed blocks
        send_request(CMD_LIST, 64'd0, 4'd0, 3'd0);
        drain_results();
    endtask

    // fill most of the map, then run out of entries
    task automatic test_capacity();
        for (int k = 0; k < 20; k++)
            send_request(CMD_CREATE, 64'h100 + k, 4'd8, 3'($urandom_range(0, 7)));
        send_request(CMD_CREATE, 64'h200, 4'd0, 3'd0);
        send_request(CMD_CREATE, 64'h201, 4'd1, 3'd0);
        send_request(CMD_LIST, 64'd0, 4'd0, 3'd0);                 // sixteen results
        drain_results();
        for (int k = 0; k < NUM_ENTRIES; k++)
            if (shadow_used[k])
                send_request(CMD_DELETE, shadow_name[k], 4'd0, 3'd0);
        send_request(CMD_LIST, 64'd0, 4'd0, 3'd0);
        drain_results();
    endtask

    // mostly create/map/delete on a small name pool, some list and random noise
    task automatic test_random(int count);
        int sel;
        logic [63:0] nm;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 99);
            nm  = name_pool[$urandom_range(0, 5)];
            if (sel < 35)
                send_request(CMD_CREATE, nm,
                             $urandom_range(0, 9) == 0 ? 4'($urandom_range(9, 15))
                                                       : 4'($urandom_range(0, 8)),
                             3'($urandom_range(0, 7)));
            else if (sel < 55)
                send_request(CMD_DELETE, nm, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
            else if (sel < 85)
                send_request(CMD_MAP, nm, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
            else if (sel < 92)
                send_request(CMD_LIST, {$urandom, $urandom}, 4'($urandom_range(0, 15)),
                             3'($urandom_range(0, 7)));
            else
                send_request(2'($urandom_range(0, 3)), {$urandom, $urandom},
                             4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
            // pause now and then until every expected result has come back
            if (k % 120 == 119) drain_results();
        end
        drain_results();
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_cmd         = CMD_CREATE;
        i_file_name   = '0;
        i_req_size    = '0;
        i_block_index = '0;
        i_stall       = 1'b0;
        stall_mode    = 0;
        stall_run     = 0;
        mismatches    = 0;
        burst_left    = 0;
        idle_cycles   = 0;
        shadow_free   = '1;
        shadow_free[0] = 1'b0;
        shadow_used   = '0;
        name_pool[0] = 64'd0;
        name_pool[1] = '1;
        name_pool[2] = 64'h6174_6164;
        name_pool[3] = {$urandom, $urandom};
        name_pool[4] = {$urandom, $urandom};
        name_pool[5] = 64'h8000_0000_0000_0000;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_capacity();
        test_random(300);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== file_table_block_allocator.f =====
design/fta_pkg.sv
design/fta_ram.sv
design/file_table_block_allocator.sv
dv/tb_file_table_block_allocator.sv
